[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge out of reset.
`define SHBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// Check that a condition never occurs out of reset.
`define SHBF_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

[rtl/core/shbf_pkg.sv]
// ----------------------------------------------------------------------------
// shbf_pkg
// Types and constants shared by the string hash bitmap filter.
// ----------------------------------------------------------------------------
package shbf_pkg;

  // Table size in entries; a power of two, so the bucket is a low-bit mask.
  localparam int unsigned TABLE_BITS = 65536;
  localparam int unsigned IDX_W      = $clog2(TABLE_BITS);

  // Bitmap storage: one memory row holds WORD_W table bits.
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BIT_W      = $clog2(WORD_W);
  localparam int unsigned ROWS       = TABLE_BITS / WORD_W;
  localparam int unsigned ROW_W      = IDX_W - BIT_W;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned BUCKET_W   = 16;

  // Result queue.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Request type codes.
  localparam logic REQ_QUERY  = 1'b0;
  localparam logic REQ_RECORD = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] char_in;
  } in_req_t;

  typedef struct packed {
    logic                was_set;
    logic [BUCKET_W-1:0] bucket;
  } out_rsp_t;

  // Lookup request from the hash stage to the bitmap stage.
  typedef struct packed {
    logic             vld;
    logic             record;
    logic [IDX_W-1:0] idx;
  } lkp_req_t;

  // Bitmap stage status toward the top level.
  typedef struct packed {
    logic busy;
    logic s1_vld;
  } bm_stat_t;

endpackage

[rtl/core/string_hash_bitmap_filter.sv]
// ----------------------------------------------------------------------------
// string_hash_bitmap_filter
// Byte-serial name hash with a one-bit-per-bucket membership table.
// ----------------------------------------------------------------------------
// Usage:
//   Send a name one byte per request on in_data.char_in, ended by a zero
//   byte. Nonzero bytes fold into h = 37*h + (signed byte) and give no result.
//   The zero byte looks up bucket h mod TABLE_BITS; in_data.req_type on that
//   byte picks query (report only) or record (report, then set the bit).
//   One result request per name appears on out_data: the bit before any
//   record, and the bucket (low 16 bits of the index).
// Throughput: one byte per cycle while in_stall is low, names back to back
//   and terminators included. Bitmap: 1024 x 64 RAM; each terminator costs
//   one read and at most one write; a row written as it is read is forwarded.
// Result path: the zero byte's lookup reads the RAM into the lookup stage,
//   then its result is pushed into a four-entry queue that drives out_valid.
// Stall: while the receiver holds out_stall, results queue up; in_stall rises
//   once the queue plus the result in flight reach four, and bytes hold.
// Reset: rst_n clears the accumulator and starts a sweep that zeroes all
//   1024 bitmap rows; in_stall stays high until the sweep completes.
// ----------------------------------------------------------------------------
module string_hash_bitmap_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  shbf_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output shbf_pkg::out_rsp_t out_data
);
  import shbf_pkg::*;

  lkp_req_t              lkp;
  bm_stat_t              stat;
  logic                  rsp_vld;
  out_rsp_t              rsp;
  logic [FIFO_CNT_W-1:0] q_cnt;
  logic [FIFO_CNT_W-1:0] occ;
  logic                  accept;
  logic                  pop;

  // Count the result in the lookup stage as already queued.
  assign occ      = q_cnt + FIFO_CNT_W'(stat.s1_vld);
  assign in_stall = stat.busy || (occ == FIFO_CNT_W'(FIFO_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // Fold bytes; raise a lookup on the zero byte.
  shbf_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .lkp     (lkp)
  );

  // Read the bucket row, report its bit, write back on record.
  shbf_bitmap u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .lkp     (lkp),
    .stat    (stat),
    .rsp_vld (rsp_vld),
    .rsp     (rsp)
  );

  // Hold results while the receiver stalls.
  shbf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rsp_vld),
    .push_data (rsp),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (out_data),
    .count     (q_cnt)
  );

endmodule

[rtl/core/shbf_ram.sv]
// ----------------------------------------------------------------------------
// shbf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module shbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/shbf_hash.sv]
// ----------------------------------------------------------------------------
// shbf_hash
// Name accumulator: folds bytes, issues a lookup on the terminating zero.
// ----------------------------------------------------------------------------
module shbf_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  shbf_pkg::in_req_t in_data,
  output shbf_pkg::lkp_req_t lkp
);
  import shbf_pkg::*;

  logic [HASH_W-1:0] acc_r;
  logic [HASH_W-1:0] acc_nxt;
  logic [HASH_W-1:0] sext;
  logic              term;

  assign term = (in_data.char_in == '0);
  assign sext = {{(HASH_W-CHAR_W){in_data.char_in[CHAR_W-1]}}, in_data.char_in};

  // 37*h + s as shift-add, wrapping at 32 bits
  always_comb begin
    acc_nxt = acc_r;
    if (accept) begin
      if (term) begin
        acc_nxt = '0;
      end else begin
        acc_nxt = (acc_r << 5) + (acc_r << 2) + acc_r + sext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign lkp.vld    = accept && term;
  assign lkp.record = (in_data.req_type == REQ_RECORD);
  assign lkp.idx    = acc_r[IDX_W-1:0];

endmodule

[rtl/core/shbf_bitmap.sv]
// ----------------------------------------------------------------------------
// shbf_bitmap
// Bitmap read-modify-write with same-row forwarding and reset clear sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shbf_bitmap (
  input  logic                clk,
  input  logic                rst_n,
  input  shbf_pkg::lkp_req_t  lkp,
  output shbf_pkg::bm_stat_t  stat,
  output logic                rsp_vld,
  output shbf_pkg::out_rsp_t  rsp
);
  import shbf_pkg::*;

  logic             clr_busy_r, clr_busy_nxt;
  logic [ROW_W-1:0] clr_row_r, clr_row_nxt;

  logic             s1_vld_r;
  logic             s1_rec_r;
  logic [IDX_W-1:0] s1_idx_r;

  logic              fw_vld_r;
  logic [ROW_W-1:0]  fw_row_r;
  logic [WORD_W-1:0] fw_data_r;

  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] cur_word;
  logic [ROW_W-1:0]  s1_row;
  logic [BIT_W-1:0]  s1_bit;
  logic              s1_wr;

  assign s1_row = s1_idx_r[IDX_W-1:BIT_W];
  assign s1_bit = s1_idx_r[BIT_W-1:0];

  // take the row written last cycle; the RAM read returned the old word
  assign cur_word = (fw_vld_r && (fw_row_r == s1_row)) ? fw_data_r : rd_data;
  assign s1_wr    = s1_vld_r && s1_rec_r;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_row_nxt  = clr_row_r;
    if (clr_busy_r) begin
      clr_row_nxt = clr_row_r + 1'b1;
      if (clr_row_r == ROW_W'(ROWS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_row_r;
      wr_data = '0;
    end else begin
      wr_en   = s1_wr;
      wr_addr = s1_row;
      wr_data = cur_word | (WORD_W'(1) << s1_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
      s1_vld_r   <= 1'b0;
      fw_vld_r   <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_row_r  <= clr_row_nxt;
      s1_vld_r   <= lkp.vld;
      fw_vld_r   <= s1_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (lkp.vld) begin
      s1_rec_r <= lkp.record;
      s1_idx_r <= lkp.idx;
    end
    fw_row_r  <= wr_addr;
    fw_data_r <= wr_data;
  end

  shbf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (lkp.vld),
    .rd_addr (lkp.idx[IDX_W-1:BIT_W]),
    .rd_data (rd_data)
  );

  assign stat.busy   = clr_busy_r;
  assign stat.s1_vld = s1_vld_r;
  assign rsp_vld     = s1_vld_r;
  assign rsp.was_set = cur_word[s1_bit];
  assign rsp.bucket  = BUCKET_W'(s1_idx_r);

  `SHBF_NEVER(a_no_lookup_in_clear, lkp.vld && clr_busy_r)
  `SHBF_NEVER(a_no_stage_in_clear, s1_vld_r && clr_busy_r)

endmodule

[rtl/core/shbf_fifo.sv]
// ----------------------------------------------------------------------------
// shbf_fifo
// Small result queue decoupling the lookup stage from the output stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shbf_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  shbf_pkg::out_rsp_t                  push_data,
  input  logic                                pop,
  output logic                                not_empty,
  output shbf_pkg::out_rsp_t                  head,
  output logic [shbf_pkg::FIFO_CNT_W-1:0]     count
);
  import shbf_pkg::*;

  out_rsp_t              entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign count     = cnt_r;

  `SHBF_NEVER(a_push_when_full, push && !pop && (cnt_r == FIFO_CNT_W'(FIFO_DEPTH)))
  `SHBF_ASSERT(a_pop_drains, (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))

endmodule

[sim/string_hash_bitmap_filter_tb.sv]
// ----------------------------------------------------------------------------
// string_hash_bitmap_filter_tb
// Self-checking bench for the byte-serial name hash membership filter.
// ----------------------------------------------------------------------------
// Feeds names one byte per request, each ended by a zero byte, and keeps a
// shadow of the accumulator and the bitmap to predict every lookup result.
// A short directed part covers the empty name, sign-extended bytes and hash
// wrap. A random part then reuses a small pool of names so that record and
// query requests hit the same buckets. Both channels idle at random, one
// stretch runs with no idling at all, and one long receiver hold fills the
// result queue so that the block has to stall its input.
// ----------------------------------------------------------------------------
module string_hash_bitmap_filter_tb;
  import shbf_pkg::*;

  localparam int unsigned IDLE_PCT     = 33;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Longest quiet spell allowed: the bitmap sweep after reset and the long
  // receiver hold both fit well inside this.
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned N_ITEMS      = 900;
  localparam int unsigned POOL_N       = 16;
  localparam int unsigned NAME_MAX     = 12;
  // Margin to watch for stray results after the last owed one.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [HASH_W-1:0] HASH_MULT = 32'd37;
  localparam logic [CHAR_W-1:0] END_CHAR  = 8'h00;

  // Shadow of the filter: running hash, bitmap and the lookups still owed.
  class filter_shadow;
    bit                seen_map [TABLE_BITS];
    logic [HASH_W-1:0] name_hash;
    out_rsp_t          owed_rsp [$];
    int unsigned       mismatches;

    function new();
      name_hash  = '0;
      mismatches = 0;
    endfunction

    // Fold a nonzero byte as a signed value; on the zero byte look up the
    // bucket, set it on record, and clear the hash.
    function void note_request(in_req_t req);
      logic [HASH_W-1:0] folded;
      int unsigned       slot;
      out_rsp_t          rsp;
      if (req.char_in != END_CHAR) begin
        folded    = {{(HASH_W-CHAR_W){req.char_in[CHAR_W-1]}}, req.char_in};
        name_hash = name_hash * HASH_MULT + folded;
      end else begin
        slot        = name_hash % TABLE_BITS;
        rsp.was_set = seen_map[slot];
        rsp.bucket  = slot[BUCKET_W-1:0];
        if (req.req_type == REQ_RECORD) seen_map[slot] = 1'b1;
        owed_rsp.insert(owed_rsp.size(), rsp);
        name_hash = '0;
      end
    endfunction

    task flag_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(out_rsp_t got);
      out_rsp_t want;
      if (owed_rsp.size() == 0) begin
        flag_mismatch($sformatf("result with no lookup pending, bucket %h", got.bucket));
      end else begin
        want = owed_rsp.pop_front();
        if (got.was_set !== want.was_set)
          flag_mismatch($sformatf("was_set %b, want %b (bucket %h)",
                                  got.was_set, want.was_set, want.bucket));
        if (got.bucket !== want.bucket)
          flag_mismatch($sformatf("bucket %h, want %h", got.bucket, want.bucket));
      end
    endtask

    function int unsigned pending();
      return owed_rsp.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  filter_shadow shadow = new();

  bit          idle_on   = 1'b1;
  bit          hold_kick = 1'b0;
  int unsigned sent_cnt  = 0;
  int unsigned quiet_cycles = 0;

  // Name pool for the random part; reuse makes record/query pairs collide.
  logic [CHAR_W-1:0] pool_chars [POOL_N][NAME_MAX];
  int unsigned       pool_len   [POOL_N];

  string_hash_bitmap_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_req_t pack_req(logic rt, logic [CHAR_W-1:0] ch);
    in_req_t req;
    req.req_type = rt;
    req.char_in  = ch;
    return req;
  endfunction

  // Offer one request; optionally drop valid for a random run of cycles first.
  // Hold the payload until the edge that accepts it, then note it in the shadow.
  task automatic send_req(in_req_t req);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (idle_on && $urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    shadow.note_request(req);
    sent_cnt++;
  endtask

  task automatic regen_name(int unsigned k);
    pool_len[k] = $urandom_range(0, NAME_MAX);
    for (int i = 0; i < NAME_MAX; i++) begin
      if ($urandom_range(99) < 70) pool_chars[k][i] = CHAR_W'($urandom_range(8'h61, 8'h7A));
      else pool_chars[k][i] = CHAR_W'($urandom_range(1, 255));
    end
  endtask

  // Send a pooled name with noise on the type bit of its characters; only
  // the terminator's type counts.
  task automatic send_name(int unsigned k, logic rt);
    for (int i = 0; i < pool_len[k]; i++)
      send_req(pack_req(1'($urandom_range(1)), pool_chars[k][i]));
    send_req(pack_req(rt, END_CHAR));
  endtask

  // Accept results on any edge with valid high and stall low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) shadow.check_result(out_data);
  end

  // Receiver: random stall, none while idling is off, and one long hold on
  // request from the stimulus.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_kick) begin
        hold_kick = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned k;
    bit          hold_done;
    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty name: bucket zero reads clear, record sets it, the query hits.
    send_req(pack_req(REQ_QUERY, END_CHAR));
    send_req(pack_req(REQ_RECORD, END_CHAR));
    send_req(pack_req(REQ_QUERY, END_CHAR));

    // 0xFF folds as minus one: hash wraps to all ones, the top bucket.
    // The type bit on the character itself must be ignored.
    send_req(pack_req(REQ_RECORD, 8'hFF));
    send_req(pack_req(REQ_RECORD, END_CHAR));
    send_req(pack_req(REQ_QUERY, 8'hFF));
    send_req(pack_req(REQ_QUERY, END_CHAR));

    // Most negative, most positive and smallest byte values in one name.
    send_req(pack_req(REQ_QUERY, 8'h80));
    send_req(pack_req(REQ_QUERY, 8'h7F));
    send_req(pack_req(REQ_QUERY, 8'h01));
    send_req(pack_req(REQ_QUERY, END_CHAR));

    // Eight negative bytes: the multiply wraps several times.
    for (int i = 0; i < 8; i++) send_req(pack_req(REQ_RECORD, 8'hFE));
    send_req(pack_req(REQ_RECORD, END_CHAR));

    for (int j = 0; j < POOL_N; j++) regen_name(j);

    // Random names from the pool; replace a name now and then so that both
    // fresh buckets and repeated hits show up.
    while (sent_cnt < N_ITEMS) begin
      if (!hold_done && sent_cnt >= 250) begin
        hold_kick = 1'b1;
        hold_done = 1'b1;
      end
      idle_on = !(sent_cnt >= 450 && sent_cnt < 650);
      k = $urandom_range(POOL_N - 1);
      if ($urandom_range(99) < 30) regen_name(k);
      send_name(k, 1'($urandom_range(1)));
    end
    idle_on = 1'b1;
    in_valid <= 1'b0;

    // Drain: wait for every owed lookup, then watch for strays.
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[string_hash_bitmap_filter.f]
+incdir+rtl/core
rtl/core/shbf_pkg.sv
rtl/core/shbf_ram.sv
rtl/core/shbf_hash.sv
rtl/core/shbf_bitmap.sv
rtl/core/shbf_fifo.sv
rtl/core/string_hash_bitmap_filter.sv
sim/string_hash_bitmap_filter_tb.sv
